FILE: rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and codes for the replicated log table.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int IDX_W  = 48;
    localparam int TIME_W = 64;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 11;
    localparam int CMD_W  = 3;
    localparam int STS_W  = 3;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPLY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEANUP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd6;

    localparam logic [STS_W-1:0] STS_OK            = 3'd0;
    localparam logic [STS_W-1:0] STS_TOO_LARGE     = 3'd1;
    localparam logic [STS_W-1:0] STS_FULL          = 3'd2;
    localparam logic [STS_W-1:0] STS_NOT_FOUND     = 3'd3;
    localparam logic [STS_W-1:0] STS_NOT_COMMITTED = 3'd4;

    localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  term;
        logic [TIME_W-1:0] tstamp;
        logic [SIZE_W-1:0] size;
        logic              committed;
        logic              applied;
    } slot_t;

endpackage

FILE: rtl/rlt_if.sv
// ----------------------------------------------------------------------------
// rlt_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface rlt_req_if;
    import rlt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_term_in;
    logic [SIZE_W-1:0] payload_size;
    logic [TIME_W-1:0] now_time;
    logic [IDX_W-1:0]  target_index;

    modport source (output valid, command, entry_term_in, payload_size, now_time,
                    target_index, input ready);
    modport sink   (input valid, command, entry_term_in, payload_size, now_time,
                    target_index, output ready);
endinterface

interface rlt_res_if;
    import rlt_pkg::*;
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  found_term;
    logic [TIME_W-1:0] found_time;
    logic [SIZE_W-1:0] found_size;
    logic [1:0]        found_flags;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  newest_entry;
    logic [IDX_W-1:0]  commit_mark;
    logic [IDX_W-1:0]  applied_mark;
    logic [IDX_W-1:0]  replicated_total;
    logic [IDX_W-1:0]  committed_total;
    logic [IDX_W-1:0]  applied_total;

    modport source (output valid, status, found_term, found_time, found_size,
                    found_flags, count, newest_entry, commit_mark, applied_mark,
                    replicated_total, committed_total, applied_total, input ready);
    modport sink   (input valid, status, found_term, found_time, found_size,
                    found_flags, count, newest_entry, commit_mark, applied_mark,
                    replicated_total, committed_total, applied_total, output ready);
endinterface

FILE: rtl/rlt_store.sv
// ----------------------------------------------------------------------------
// rlt_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rlt_store
    import rlt_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  slot_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output slot_t                    rdata
);

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/replicated_log_table_core.sv
// ----------------------------------------------------------------------------
// replicated_log_table_core
// Ordered log entry table held in one synchronous memory.
// ----------------------------------------------------------------------------
// One command at a time. Append, reset and the unused code pass from the
// execute state to the done state and there load the result register.
// Commit, apply, read, count and cleanup walk the entry memory from the
// oldest slot through its single read port, one entry a cycle: a lookup
// stops at the slot that it hits, while a miss, a count and a cleanup walk
// every occupied slot. The input is ready again as soon as the result is
// loaded. Cleanup compacts in place through the write port while the walk
// proceeds. The result sits in an output register; while it waits, a
// finished command holds in place and the input is not ready.
module replicated_log_table_core
    import rlt_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    rlt_req_if.sink           request,
    rlt_res_if.source         result
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int OW = $clog2(LOG_DEPTH + 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(LOG_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [SIZE_W-1:0] max_reg;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [IDX_W-1:0]  newest_reg, newest_next;
    logic [IDX_W-1:0]  hc_reg, hc_next;
    logic [IDX_W-1:0]  ha_reg, ha_next;
    logic [IDX_W-1:0]  rc_reg, rc_next;
    logic [IDX_W-1:0]  cc_reg, cc_next;
    logic [IDX_W-1:0]  ac_reg, ac_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  term_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [TIME_W-1:0] now_reg;
    logic [IDX_W-1:0]  tgt_reg;

    logic [OW-1:0]     ptr_reg, ptr_next;
    logic              rv_reg, rv_next;
    logic [AW-1:0]     raddr_reg;
    logic [OW-1:0]     kept_reg, kept_next;
    logic [OW-1:0]     cnt_reg, cnt_next;
    logic              cnt_set_reg, cnt_set_next;

    logic [STS_W-1:0]  sts_reg, sts_next;
    slot_t             hit_reg, hit_next;

    logic              ovalid_reg;
    logic              out_free;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    slot_t             mem_wdata;
    slot_t             mem_rdata;
    slot_t             app_slot;
    logic [OW+CNT_W-1:0] cnt_ext;

    rlt_store #(
        .DEPTH (LOG_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign out_free      = !ovalid_reg || result.ready;

    always_comb
    begin
        app_slot.idx       = newest_reg + IDX_W'(1);
        app_slot.term      = term_reg;
        app_slot.tstamp    = now_reg;
        app_slot.size      = size_reg;
        app_slot.committed = 1'b0;
        app_slot.applied   = 1'b0;
    end

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        newest_next  = newest_reg;
        hc_next      = hc_reg;
        ha_next      = ha_reg;
        rc_next      = rc_reg;
        cc_next      = cc_reg;
        ac_next      = ac_reg;
        ptr_next     = ptr_reg;
        rv_next      = 1'b0;
        kept_next    = kept_reg;
        cnt_next     = cnt_reg;
        cnt_set_next = cnt_set_reg;
        sts_next     = sts_reg;
        hit_next     = hit_reg;
        mem_we       = 1'b0;
        mem_waddr    = occ_reg[AW-1:0];
        mem_wdata    = app_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                sts_next     = STS_OK;
                hit_next     = '0;
                cnt_set_next = 1'b0;
                cnt_next     = '0;
                kept_next    = '0;
                ptr_next     = '0;
                state_next   = S_DONE;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (size_reg > max_reg)
                        begin
                            sts_next = STS_TOO_LARGE;
                        end
                        else if (occ_reg == FULL_OCC)
                        begin
                            sts_next = STS_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            newest_next = app_slot.idx;
                            occ_next    = occ_reg + OW'(1);
                        end
                    end
                    CMD_COMMIT, CMD_APPLY, CMD_READ, CMD_COUNT, CMD_CLEANUP:
                    begin
                        state_next   = S_SCAN;
                        cnt_set_next = (cmd_reg == CMD_COUNT) || (cmd_reg == CMD_CLEANUP);
                    end
                    CMD_RESET:
                    begin
                        occ_next    = '0;
                        newest_next = '0;
                        hc_next     = '0;
                        ha_next     = '0;
                        rc_next     = '0;
                        cc_next     = '0;
                        ac_next     = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SCAN:
            begin
                // read ahead one slot; rdata belongs to raddr_reg
                if (ptr_reg < occ_reg)
                begin
                    rv_next  = 1'b1;
                    ptr_next = ptr_reg + OW'(1);
                end
                if (rv_reg)
                begin
                    case (cmd_reg)
                        CMD_COUNT:
                        begin
                            if (mem_rdata.idx >= tgt_reg)
                            begin
                                cnt_next = cnt_reg + OW'(1);
                            end
                        end
                        CMD_CLEANUP:
                        begin
                            if (mem_rdata.idx >= tgt_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = kept_reg[AW-1:0];
                                mem_wdata = mem_rdata;
                                kept_next = kept_reg + OW'(1);
                            end
                            else
                            begin
                                cnt_next = cnt_reg + OW'(1);
                            end
                        end
                        default:
                        begin
                            if (mem_rdata.idx == tgt_reg)
                            begin
                                state_next = S_DONE;
                                rv_next    = 1'b0;
                                mem_waddr  = raddr_reg;
                                mem_wdata  = mem_rdata;
                                if (cmd_reg == CMD_COMMIT)
                                begin
                                    mem_we              = 1'b1;
                                    mem_wdata.committed = 1'b1;
                                    cc_next             = cc_reg + IDX_W'(1);
                                    if (tgt_reg > hc_reg)
                                    begin
                                        hc_next = tgt_reg;
                                    end
                                end
                                else if (cmd_reg == CMD_APPLY)
                                begin
                                    if (!mem_rdata.committed)
                                    begin
                                        sts_next = STS_NOT_COMMITTED;
                                    end
                                    else
                                    begin
                                        mem_we            = 1'b1;
                                        mem_wdata.applied = 1'b1;
                                        ac_next           = ac_reg + IDX_W'(1);
                                        if (tgt_reg > ha_reg)
                                        begin
                                            ha_next = tgt_reg;
                                        end
                                    end
                                end
                                else
                                begin
                                    hit_next = mem_rdata;
                                end
                            end
                        end
                    endcase
                end
                else if (ptr_reg >= occ_reg)
                begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_COUNT:   rc_next  = rc_reg + IDX_W'(cnt_reg);
                        CMD_CLEANUP: occ_next = kept_reg;
                        default:     sts_next = STS_NOT_FOUND;
                    endcase
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            max_reg     <= MAX_PAYLOAD_RST;
            occ_reg     <= '0;
            newest_reg  <= '0;
            hc_reg      <= '0;
            ha_reg      <= '0;
            rc_reg      <= '0;
            cc_reg      <= '0;
            ac_reg      <= '0;
            rv_reg      <= 1'b0;
            ptr_reg     <= '0;
            kept_reg    <= '0;
            cnt_reg     <= '0;
            cnt_set_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            newest_reg  <= newest_next;
            hc_reg      <= hc_next;
            ha_reg      <= ha_next;
            rc_reg      <= rc_next;
            cc_reg      <= cc_next;
            ac_reg      <= ac_next;
            rv_reg      <= rv_next;
            ptr_reg     <= ptr_next;
            kept_reg    <= kept_next;
            cnt_reg     <= cnt_next;
            cnt_set_reg <= cnt_set_next;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign cnt_ext = {{CNT_W{1'b0}}, (cnt_set_reg ? cnt_reg : occ_reg)};

    // payload registers
    always_ff @(posedge clk)
    begin
        raddr_reg <= ptr_reg[AW-1:0];
        sts_reg   <= sts_next;
        hit_reg   <= hit_next;
        if (request.valid && request.ready)
        begin
            cmd_reg  <= request.command;
            term_reg <= request.entry_term_in;
            size_reg <= request.payload_size;
            now_reg  <= request.now_time;
            tgt_reg  <= request.target_index;
        end
        if (state_reg == S_DONE && out_free)
        begin
            result.status           <= sts_reg;
            result.found_term       <= hit_reg.term;
            result.found_time       <= hit_reg.tstamp;
            result.found_size       <= hit_reg.size;
            result.found_flags      <= {hit_reg.applied, hit_reg.committed};
            result.count            <= cnt_ext[CNT_W-1:0];
            result.newest_entry     <= newest_reg;
            result.commit_mark      <= hc_reg;
            result.applied_mark     <= ha_reg;
            result.replicated_total <= rc_reg;
            result.committed_total  <= cc_reg;
            result.applied_total    <= ac_reg;
        end
    end

    assign result.valid = ovalid_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_OCC)
        else $error("occupancy above table depth");

    a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (kept_reg <= ptr_reg))
        else $error("compaction write overtook the read pointer");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (state_reg == S_IDLE && ovalid_reg))
        else $error("result not loaded on completion");

    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_we) |-> (mem_waddr < occ_reg[AW-1:0] ||
                                             occ_reg == FULL_OCC))
        else $error("scan write beyond occupied slots");
`endif

endmodule
